/* rtl/stps_pkg.sv */
`timescale 1ns / 1ps

package stps_pkg;

    localparam int unsigned IDX_W = 11;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned SUM_W = 48;

    // s_axis_tdata: first_index, last_index, leaf_value, zero pad to whole bytes
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 48;

    localparam logic OP_SET = 1'b0;
    localparam logic OP_SUM = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET_UP,
        ST_Q_WALK,
        ST_Q_DONE
    } stps_state_t;

endpackage

/* rtl/stps_node_ram.sv */
`timescale 1ns / 1ps

module stps_node_ram #(
    parameter int unsigned ADDR_BITS = 11,
    parameter int unsigned DATA_BITS = 48
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read-before-write on a shared address
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/segment_tree_point_set_range_sum.sv */
`timescale 1ns / 1ps

// Segment tree over LEAF_COUNT leaves (a power of two), numbered from 1, with
// all node sums held in one RAM of 2*LEAF_COUNT words, 48 bits wide, one
// read and one write port, registered read data. After reset the block clears
// the RAM one word per cycle and holds s_axis_tready low meanwhile. One
// transaction is worked at a time. A set writes the leaf and then recomputes
// one ancestor per cycle from the sibling read in the cycle before. A sum
// walks the tree from both ends of the range, at most one RAM read per cycle;
// an empty range skips the walk. A set outside 1..LEAF_COUNT is dropped and
// gives no result; a sum range is clipped to the leaves and gives zero when
// empty. The result register lets the next transaction in while a total
// waits on m_axis_tready.
module segment_tree_point_set_range_sum
    import stps_pkg::*;
#(
    parameter int unsigned LEAF_COUNT = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [10:0] first_index, [21:11] last_index, [53:22] leaf_value, [55:54] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [47:0] range_total
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int unsigned LEAF_BITS = $clog2(LEAF_COUNT);
    localparam int unsigned NODE_BITS = LEAF_BITS + 1;
    localparam int unsigned PTR_BITS  = LEAF_BITS + 2;
    localparam int unsigned CMP_BITS  = ((PTR_BITS > IDX_W) ? PTR_BITS : IDX_W) + 1;

    localparam logic [CMP_BITS-1:0]  LEAVES   = CMP_BITS'(LEAF_COUNT);
    localparam logic [NODE_BITS-1:0] ROOT_POS = NODE_BITS'(1);

    stps_state_t state_reg, state_next;

    logic [NODE_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [NODE_BITS-1:0] pos_reg, pos_next;
    logic [PTR_BITS-1:0]  l_reg, l_next;
    logic [PTR_BITS-1:0]  r_reg, r_next;
    logic                 pend_reg, pend_next;
    logic [SUM_W-1:0]     cur_reg, cur_next;
    logic [SUM_W-1:0]     acc_reg, acc_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]     out_data_reg, out_data_next;

    logic                 ram_we;
    logic [NODE_BITS-1:0] ram_waddr;
    logic [SUM_W-1:0]     ram_wdata;
    logic [NODE_BITS-1:0] ram_raddr;
    logic [SUM_W-1:0]     ram_rdata;

    logic [IDX_W-1:0]    in_first;
    logic [IDX_W-1:0]    in_last;
    logic [VAL_W-1:0]    in_value;
    logic [CMP_BITS-1:0] first_ext;
    logic [CMP_BITS-1:0] last_ext;
    logic [CMP_BITS-1:0] lo_clip;
    logic [CMP_BITS-1:0] hi_clip;
    logic [CMP_BITS-1:0] leaf_node;
    logic [CMP_BITS-1:0] l_start;
    logic [CMP_BITS-1:0] r_start;
    logic                set_ok;
    logic                range_empty;
    logic [SUM_W-1:0]    value_ext;
    logic [SUM_W-1:0]    up_sum;
    logic [NODE_BITS-1:0] parent;
    logic                in_fire;

    assign in_first = s_axis_tdata[IDX_W-1:0];
    assign in_last  = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign in_value = s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];

    assign first_ext   = CMP_BITS'(in_first);
    assign last_ext    = CMP_BITS'(in_last);
    assign lo_clip     = (first_ext == '0) ? CMP_BITS'(1) : first_ext;
    assign hi_clip     = (last_ext > LEAVES) ? LEAVES : last_ext;
    assign range_empty = lo_clip > hi_clip;
    assign set_ok      = (first_ext != '0) && (first_ext <= LEAVES);
    assign leaf_node   = LEAVES + first_ext - CMP_BITS'(1);
    assign l_start     = LEAVES + lo_clip - CMP_BITS'(1);
    assign r_start     = LEAVES + hi_clip;
    assign value_ext   = {{(SUM_W-VAL_W){in_value[VAL_W-1]}}, in_value};

    assign up_sum = cur_reg + ram_rdata;
    assign parent = pos_reg >> 1;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    stps_node_ram #(
        .ADDR_BITS (NODE_BITS),
        .DATA_BITS (SUM_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        pos_next       = pos_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        pend_next      = 1'b0;
        cur_next       = cur_reg;
        acc_next       = pend_reg ? (acc_reg + ram_rdata) : acc_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = clr_cnt_reg;
        ram_wdata      = '0;
        ram_raddr      = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + NODE_BITS'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser == OP_SET)
                    begin
                        if (set_ok)
                        begin
                            // write the leaf, fetch its sibling for the first parent
                            ram_we     = 1'b1;
                            ram_waddr  = leaf_node[NODE_BITS-1:0];
                            ram_wdata  = value_ext;
                            ram_raddr  = leaf_node[NODE_BITS-1:0] ^ NODE_BITS'(1);
                            pos_next   = leaf_node[NODE_BITS-1:0];
                            cur_next   = value_ext;
                            state_next = ST_SET_UP;
                        end
                    end
                    else
                    begin
                        acc_next = '0;
                        l_next   = l_start[PTR_BITS-1:0];
                        r_next   = r_start[PTR_BITS-1:0];
                        state_next = range_empty ? ST_Q_DONE : ST_Q_WALK;
                    end
                end
            end

            ST_SET_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = up_sum;
                ram_raddr = parent ^ NODE_BITS'(1);
                cur_next  = up_sum;
                pos_next  = parent;
                if (parent == ROOT_POS)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_Q_WALK:
            begin
                // half-open [l, r); at most one node read per cycle
                if (l_reg >= r_reg)
                begin
                    state_next = ST_Q_DONE;
                end
                else if (l_reg[0])
                begin
                    ram_raddr = l_reg[NODE_BITS-1:0];
                    pend_next = 1'b1;
                    if (r_reg[0])
                    begin
                        l_next = l_reg + PTR_BITS'(1);
                    end
                    else
                    begin
                        l_next = (l_reg + PTR_BITS'(1)) >> 1;
                        r_next = r_reg >> 1;
                    end
                end
                else if (r_reg[0])
                begin
                    ram_raddr = NODE_BITS'(r_reg - PTR_BITS'(1));
                    pend_next = 1'b1;
                    l_next    = l_reg >> 1;
                    r_next    = (r_reg - PTR_BITS'(1)) >> 1;
                end
                else
                begin
                    l_next = l_reg >> 1;
                    r_next = r_reg >> 1;
                end
            end

            ST_Q_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            l_reg         <= '0;
            r_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            l_reg         <= l_next;
            r_reg         <= r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        cur_reg      <= cur_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    // a total is only loaded from the finish state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_Q_DONE))
        else $error("result loaded outside query finish");

    // node 0 is never written once the clearing pass is over
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != ST_CLEAR) |-> (ram_waddr != '0))
        else $error("write to unused node 0");

    // query interval never inverts
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q_WALK) |-> (l_reg <= r_reg))
        else $error("query bounds crossed");

    // read data is consumed only after a walk read
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(state_reg == ST_Q_WALK))
        else $error("pending read without query walk");

    // no transaction enters during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (!s_axis_tready && !ram_we ||
                                     ram_waddr == clr_cnt_reg))
        else $error("clearing pass disturbed");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import stps_pkg::*;

    localparam int LEAVES      = 1024;
    localparam int RAND_ITEMS  = 500;
    localparam int QUIET_TAIL  = 60;   // last random items run with no idling
    localparam int DRAIN_WAIT  = 40;   // extra wait once all expected totals are in

    typedef struct {
        logic               op;
        logic [IDX_W-1:0]   first_idx;
        logic [IDX_W-1:0]   last_idx;
        logic [VAL_W-1:0]   value;
        bit                 known;      // total typed in by hand
        logic [SUM_W-1:0]   known_total;
    } tree_op_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // node sums of the shadow tree; node 1 is the root, leaf i at LEAVES+i-1
    logic [SUM_W-1:0] shadow_tree [1:2*LEAVES-1];
    logic [SUM_W-1:0] pending_totals [$];
    tree_op_t         directed_ops [$];
    int               mismatch_count;
    bit               idle_on;

    segment_tree_point_set_range_sum #(
        .LEAF_COUNT(LEAVES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic tree_op_t make_op(logic op, int unsigned first_idx,
                                         int unsigned last_idx, logic [VAL_W-1:0] value,
                                         bit known = 0, logic [SUM_W-1:0] known_total = '0);
        tree_op_t t;
        t.op          = op;
        t.first_idx   = first_idx[IDX_W-1:0];
        t.last_idx    = last_idx[IDX_W-1:0];
        t.value       = value;
        t.known       = known;
        t.known_total = known_total;
        return t;
    endfunction

    function automatic void set_leaf(int unsigned idx, logic [VAL_W-1:0] value);
        int unsigned node;
        node = LEAVES + idx - 1;
        shadow_tree[node] = {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};
        node = node >> 1;
        while (node >= 1) begin
            shadow_tree[node] = shadow_tree[2*node] + shadow_tree[2*node+1];
            node = node >> 1;
        end
    endfunction

    // bottom-up walk over the half-open node interval [lo_node, hi_node)
    function automatic logic [SUM_W-1:0] sum_leaves(int unsigned lo, int unsigned hi);
        logic [SUM_W-1:0] acc;
        int unsigned      lo_node;
        int unsigned      hi_node;
        acc = '0;
        if (lo < 1) lo = 1;
        if (hi > LEAVES) hi = LEAVES;
        if (lo > hi) return '0;
        lo_node = LEAVES + lo - 1;
        hi_node = LEAVES + hi;
        while (lo_node < hi_node) begin
            if (lo_node[0]) begin
                acc = acc + shadow_tree[lo_node];
                lo_node++;
            end
            if (hi_node[0]) begin
                hi_node--;
                acc = acc + shadow_tree[hi_node];
            end
            lo_node = lo_node >> 1;
            hi_node = hi_node >> 1;
        end
        return acc;
    endfunction

    function automatic void expect_total(logic [SUM_W-1:0] total);
        pending_totals.insert(pending_totals.size(), total);
    endfunction

    function automatic void add_row(tree_op_t t);
        directed_ops.insert(directed_ops.size(), t);
    endfunction

    // called at the edge where the transaction is accepted
    function automatic void predict(tree_op_t t);
        if (t.op == OP_SET) begin
            if (t.first_idx >= 1 && t.first_idx <= LEAVES)
                set_leaf(t.first_idx, t.value);
        end else if (t.known) begin
            expect_total(t.known_total);
        end else begin
            expect_total(sum_leaves(t.first_idx, t.last_idx));
        end
    endfunction

    // entered and left at a falling edge
    task automatic send_op(tree_op_t t);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= t.op;
        s_axis_tdata  <= {{(IN_DATA_W-2*IDX_W-VAL_W){1'b0}}, t.value, t.last_idx, t.first_idx};
        do @(posedge clk); while (!s_axis_tready);
        predict(t);
        @(negedge clk);
    endtask

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return {16'($urandom_range(0, 7) - 4), 16'h0000};
            default: return $urandom;
        endcase
    endfunction

    function automatic tree_op_t random_op();
        int unsigned lo;
        int unsigned hi;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return make_op(OP_SET, $urandom_range(1, LEAVES), $urandom_range(0, 2047),
                           random_value());
        if (pick < 50)
            return make_op(OP_SET, ($urandom_range(0, 1) ? 0 : $urandom_range(LEAVES + 1, 2047)),
                           $urandom_range(0, 2047), $urandom);
        if (pick < 90) begin
            case ($urandom_range(0, 3))
                0: begin
                    lo = $urandom_range(1, LEAVES);
                    hi = lo + $urandom_range(0, 7);
                    if (hi > LEAVES) hi = LEAVES;
                end
                1: begin
                    lo = $urandom_range(1, LEAVES);
                    hi = $urandom_range(lo, LEAVES);
                end
                2: begin
                    lo = $urandom_range(1, 4);
                    hi = $urandom_range(LEAVES - 4, LEAVES);
                end
                default: begin
                    lo = $urandom_range(1, LEAVES);
                    hi = $urandom_range(1, LEAVES);
                end
            endcase
            return make_op(OP_SUM, lo, hi, $urandom);
        end
        // unconstrained indexes: clipped, empty and wholly outside ranges
        return make_op(OP_SUM, $urandom_range(0, 2047), $urandom_range(0, 2047), $urandom);
    endfunction

    // result side: random stall bursts on m_axis_tready while idling is on
    initial begin
        int unsigned burst;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 5);
                m_axis_tready <= 1'b0;
                repeat (burst) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_totals.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected range_total %h", $realtime, m_axis_tdata);
            end else begin
                if (m_axis_tdata !== pending_totals[0]) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: range_total expected %h got %h",
                                 $realtime, pending_totals[0], m_axis_tdata);
                end
                void'(pending_totals.pop_front());
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        mismatch_count = 0;
        idle_on        = 1'b1;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tuser   = OP_SET;
        s_axis_tdata   = '0;
        foreach (shadow_tree[k]) shadow_tree[k] = '0;

        add_row(make_op(OP_SUM, 1,    LEAVES, 0, 1, 48'h0));
        add_row(make_op(OP_SUM, 0,    2047,   0, 1, 48'h0));
        add_row(make_op(OP_SET, 1,    0,      32'h7FFF_FFFF));
        add_row(make_op(OP_SET, LEAVES, 0,    32'h8000_0000));
        add_row(make_op(OP_SET, 512,  0,      32'h0001_0000));
        // sets off the leaves are dropped
        add_row(make_op(OP_SET, 0,    5,      32'h1234_5678));
        add_row(make_op(OP_SET, LEAVES + 1, 0, 32'hFFFF_FFFF));
        add_row(make_op(OP_SET, 2047, 2047,   32'h5555_5555));
        add_row(make_op(OP_SUM, 1,    1,      0, 1, 48'h0000_7FFF_FFFF));
        add_row(make_op(OP_SUM, LEAVES, LEAVES, 0, 1, 48'hFFFF_8000_0000));
        add_row(make_op(OP_SUM, 512,  512,    0, 1, 48'h0000_0001_0000));
        add_row(make_op(OP_SUM, 1,    LEAVES, 0));
        add_row(make_op(OP_SUM, 0,    2047,   32'hFFFF_FFFF));
        add_row(make_op(OP_SUM, 0,    0,      0, 1, 48'h0));
        add_row(make_op(OP_SUM, LEAVES + 1, 2047, 0, 1, 48'h0));
        add_row(make_op(OP_SUM, 600,  200,    0, 1, 48'h0));
        add_row(make_op(OP_SUM, 2047, 0,      0, 1, 48'h0));
        add_row(make_op(OP_SUM, 2,    LEAVES - 1, 0));
        add_row(make_op(OP_SUM, 1,    LEAVES - 1, 0));
        add_row(make_op(OP_SET, 1,    0,      32'hAAAA_AAAA));
        add_row(make_op(OP_SUM, 1,    2,      0));
        add_row(make_op(OP_SUM, 0,    1,      0));
        // last_index is a don't-care on a set, leaf_value on a sum
        add_row(make_op(OP_SET, 700,  2047,   32'hFFFF_0000));
        add_row(make_op(OP_SUM, 700,  700,    32'hFFFF_FFFF, 1, 48'hFFFF_FFFF_0000));

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_ops[i]) send_op(directed_ops[i]);
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS - QUIET_TAIL) idle_on = 1'b0;
            send_op(random_op());
        end
        s_axis_tvalid <= 1'b0;

        while (pending_totals.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0 && pending_totals.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
